// File: rtl/lzwh_pkg.sv
// Shared types and constants for the hashed-dictionary LZW compressor.
// No dependencies; used by the top level and by the stream interface users.
package lzwh_pkg;

	localparam int DATA_W = 8;
	localparam int CODE_W = 12;

	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              end_of_stream;
	} byte_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              final_code;
	} code_item_t;

endpackage

// File: rtl/lzwh_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is a parameter; the item types live in lzwh_pkg.
interface lzwh_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lzwh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lzwh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/lzw_hash_dictionary_compressor_top.sv
// Hashed-dictionary LZW compressor. Depends on lzwh_pkg, lzwh_stream_if, lzwh_ram.
// The first byte of a stream is only held as prefix; any other byte passes S_IDLE,
// S_HASH, S_READ and S_CHECK, stays in S_CHECK per extra probe of the dictionary
// (one read per cycle), then S_EMIT_MISS on a miss; new bytes are taken only in S_IDLE.
// Reset: control state clears at once, then a clearing pass writes all HASH_SIZE
// dictionary entries empty; the same pass runs after each end of stream.
module lzw_hash_dictionary_compressor_top #(
	parameter int MAX_BITS   = 12,
	parameter int HASH_SIZE  = 4919,
	parameter int FIRST_FREE = 257
) (
	input  logic clk,
	input  logic arst_n,
	lzwh_stream_if.sink   byte_stream,
	lzwh_stream_if.source code_stream
);

	localparam int IDX_W     = $clog2(HASH_SIZE);
	localparam int ENTRY_W   = 1 + MAX_BITS + lzwh_pkg::DATA_W + MAX_BITS;
	localparam int RED_STEPS = $clog2((1 << MAX_BITS) / HASH_SIZE + 1);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_EMIT_MISS, S_EMIT_LAST
	} state_t;

	// first probe index modulo HASH_SIZE by shifted compare-subtract steps
	function automatic logic [IDX_W-1:0] hash_reduce(input logic [MAX_BITS-1:0] v);
		logic [31:0] r;
		r = 32'(v);
		for (int k = RED_STEPS; k >= 0; k--) begin
			if (r >= (32'(HASH_SIZE) << k)) begin
				r = r - (32'(HASH_SIZE) << k);
			end
		end
		return r[IDX_W-1:0];
	endfunction

	function automatic logic [lzwh_pkg::CODE_W-1:0] to_code(input logic [MAX_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[lzwh_pkg::CODE_W-1:0];
	endfunction

	state_t                      state_q;
	logic [IDX_W-1:0]            clr_q;
	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            step_q;
	logic [IDX_W-1:0]            back_q;
	logic [IDX_W-1:0]            probe_q;
	logic                        free_q;
	logic [MAX_BITS-1:0]         prefix_q;
	logic                        held_q;
	logic [MAX_BITS-1:0]         nfc_q;
	logic [lzwh_pkg::DATA_W-1:0] byte_q;
	logic                        eos_q;

	// output queue, two items
	lzwh_pkg::code_item_t q_mem [2];
	logic                 head_q;
	logic [1:0]           cnt_q;
	logic                 q_space;
	logic                 push;
	logic                 pop;
	lzwh_pkg::code_item_t push_item;

	// dictionary memory
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	logic                        e_used;
	logic [MAX_BITS-1:0]         e_prefix;
	logic [lzwh_pkg::DATA_W-1:0] e_byte;
	logic [MAX_BITS-1:0]         e_code;
	logic [IDX_W-1:0]            nxt_idx;
	logic                        in_xfer;
	logic                        can_store;
	logic [MAX_BITS-1:0]         hash_val;

	assign e_used   = ram_rdata[ENTRY_W-1];
	assign e_prefix = ram_rdata[ENTRY_W-2 -: MAX_BITS];
	assign e_byte   = ram_rdata[MAX_BITS + lzwh_pkg::DATA_W - 1 -: lzwh_pkg::DATA_W];
	assign e_code   = ram_rdata[MAX_BITS-1:0];

	assign nxt_idx = (idx_q >= step_q) ? idx_q - step_q : idx_q + back_q;
	assign hash_val = {byte_q, (MAX_BITS - lzwh_pkg::DATA_W)'(0)} ^ prefix_q;

	assign byte_stream.ready = (state_q == S_IDLE);
	assign in_xfer = byte_stream.valid && byte_stream.ready;
	assign can_store = free_q && (nfc_q != {MAX_BITS{1'b1}});

	assign ram_raddr = (state_q == S_CHECK) ? nxt_idx : idx_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {1'b1, prefix_q, byte_q, nfc_q};
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_EMIT_MISS && q_space && can_store) begin
			ram_we = 1'b1;
		end
	end

	assign push_item.code       = to_code(prefix_q);
	assign push_item.final_code = (state_q == S_EMIT_LAST);
	assign push = q_space && (state_q == S_EMIT_MISS || state_q == S_EMIT_LAST);

	lzwh_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HASH_SIZE)
	) u_dict (
		.clk(clk),
		.we(ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			idx_q    <= '0;
			step_q   <= '0;
			back_q   <= '0;
			probe_q  <= '0;
			free_q   <= 1'b0;
			prefix_q <= '0;
			held_q   <= 1'b0;
			nfc_q    <= MAX_BITS'(FIRST_FREE);
			byte_q   <= '0;
			eos_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(HASH_SIZE - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						byte_q <= byte_stream.data.data_byte;
						eos_q  <= byte_stream.data.end_of_stream;
						if (!held_q) begin
							prefix_q <= MAX_BITS'(byte_stream.data.data_byte);
							held_q   <= 1'b1;
							state_q  <= byte_stream.data.end_of_stream ? S_EMIT_LAST : S_IDLE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					idx_q   <= hash_reduce(hash_val);
					probe_q <= '0;
					state_q <= S_READ;
				end
				S_READ: begin
					// step backwards by HASH_SIZE - idx, or by one at index zero
					if (idx_q == '0) begin
						step_q <= IDX_W'(1);
						back_q <= IDX_W'(HASH_SIZE - 1);
					end else begin
						step_q <= IDX_W'(HASH_SIZE) - idx_q;
						back_q <= idx_q;
					end
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!e_used) begin
						free_q  <= 1'b1;
						state_q <= S_EMIT_MISS;
					end else if (e_prefix == prefix_q && e_byte == byte_q) begin
						prefix_q <= e_code;
						state_q  <= eos_q ? S_EMIT_LAST : S_IDLE;
					end else if (probe_q == IDX_W'(HASH_SIZE - 1)) begin
						free_q  <= 1'b0;
						state_q <= S_EMIT_MISS;
					end else begin
						// next read already issued at nxt_idx
						idx_q   <= nxt_idx;
						probe_q <= probe_q + 1'b1;
					end
				end
				S_EMIT_MISS: begin
					if (q_space) begin
						if (can_store) begin
							nfc_q <= nfc_q + 1'b1;
						end
						prefix_q <= MAX_BITS'(byte_q);
						state_q  <= eos_q ? S_EMIT_LAST : S_IDLE;
					end
				end
				S_EMIT_LAST: begin
					if (q_space) begin
						prefix_q <= '0;
						held_q   <= 1'b0;
						nfc_q    <= MAX_BITS'(FIRST_FREE);
						state_q  <= S_CLEAR;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// output queue
	assign q_space = (cnt_q != 2'd2);
	assign code_stream.valid = (cnt_q != 2'd0);
	assign code_stream.data  = q_mem[head_q];
	assign pop = code_stream.valid && code_stream.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[head_q ^ cnt_q[0]] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (pop) begin
				head_q <= ~head_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("output queue count overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> !ram_we)
		else $error("dictionary write during probe");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && held_q) |=> (state_q == S_HASH))
		else $error("held prefix did not start a probe");

	assert property (@(posedge clk) disable iff (!arst_n)
		nfc_q >= MAX_BITS'(FIRST_FREE))
		else $error("free code below first free code");

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (state_q == S_EMIT_MISS || state_q == S_EMIT_LAST))
		else $error("result pushed outside an emit state");

endmodule

// File: bench/tb_lzw_hash_dictionary_compressor_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the hashed-dictionary LZW compressor: byte streams in, codes out.
// Depends on lzwh_pkg, lzwh_stream_if and the top level; it keeps its own copy of the dictionary.
module tb_lzw_hash_dictionary_compressor_top;

	localparam int HASH_SIZE    = 4919;
	localparam int HASH_SHIFT   = 4;       // MAX_BITS - 8
	localparam int FIRST_FREE   = 257;
	localparam int CODE_LIMIT   = 4095;    // codes are handed out while below this
	localparam int STALL_LIMIT  = 30000;   // covers the clearing pass after each stream
	localparam int DRAIN_CYCLES = 64;
	localparam int GAP_CAP      = 200;

	typedef logic [lzwh_pkg::DATA_W-1:0] byte_q_t[$];

	logic clk;
	logic arst_n;

	lzwh_stream_if #(.T(lzwh_pkg::byte_item_t)) byte_stream ();
	lzwh_stream_if #(.T(lzwh_pkg::code_item_t)) code_stream ();

	lzw_hash_dictionary_compressor_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_stream),
		.code_stream(code_stream)
	);

	// dictionary shadow
	bit                          dict_used   [HASH_SIZE];
	logic [lzwh_pkg::CODE_W-1:0] dict_prefix [HASH_SIZE];
	logic [lzwh_pkg::DATA_W-1:0] dict_byte   [HASH_SIZE];
	logic [lzwh_pkg::CODE_W-1:0] dict_code   [HASH_SIZE];
	logic [lzwh_pkg::CODE_W-1:0] cur_prefix;
	bit                          prefix_valid;
	int                          next_code;

	lzwh_pkg::code_item_t pending_codes[$];
	int                   errors;
	int                   tx_idle_pct;
	int                   rx_stall_pct;
	int                   rx_hold_len;

	always #4 clk = ~clk;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		byte_stream.valid = 1'b0;
		byte_stream.data = '0;
		code_stream.ready = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		$display("tb: mismatch, %s: got %0d, expected %0d, at %0t", what, got_v, want_v, $time);
		errors++;
	endtask

	function automatic void clear_dictionary();
		foreach (dict_used[i])
			dict_used[i] = 1'b0;
		cur_prefix = '0;
		prefix_valid = 1'b0;
		next_code = FIRST_FREE;
	endfunction

	function automatic void push_code(input logic [lzwh_pkg::CODE_W-1:0] c, input logic last);
		lzwh_pkg::code_item_t e;
		e.code = c;
		e.final_code = last;
		pending_codes.push_back(e);
	endfunction

	// Advance the shadow dictionary by one accepted byte and queue the codes it emits.
	function automatic void lzw_encode_byte(input logic [lzwh_pkg::DATA_W-1:0] b,
	                                        input logic eos);
		int slot;
		int stride;
		int probe;
		bit hit;
		bit free_slot;
		if (!prefix_valid) begin
			cur_prefix = lzwh_pkg::CODE_W'(b);
			prefix_valid = 1'b1;
		end else begin
			slot = ((int'(b) << HASH_SHIFT) ^ int'(cur_prefix)) % HASH_SIZE;
			stride = (slot == 0) ? 1 : HASH_SIZE - slot;
			hit = 1'b0;
			free_slot = 1'b0;
			for (probe = 0; probe < HASH_SIZE; probe++) begin
				if (probe != 0)
					slot = (slot >= stride) ? slot - stride : slot + HASH_SIZE - stride;
				if (!dict_used[slot]) begin
					free_slot = 1'b1;
					break;
				end
				if (dict_prefix[slot] == cur_prefix && dict_byte[slot] == b) begin
					hit = 1'b1;
					break;
				end
			end
			if (hit) begin
				cur_prefix = dict_code[slot];
			end else begin
				push_code(cur_prefix, 1'b0);
				if (free_slot && next_code < CODE_LIMIT) begin
					dict_used[slot] = 1'b1;
					dict_prefix[slot] = cur_prefix;
					dict_byte[slot] = b;
					dict_code[slot] = lzwh_pkg::CODE_W'(next_code);
					next_code++;
				end
				cur_prefix = lzwh_pkg::CODE_W'(b);
			end
		end
		if (eos) begin
			push_code(cur_prefix, 1'b1);
			clear_dictionary();
		end
	endfunction

	// Offer one byte, holding valid across back-to-back transfers.
	task automatic send_byte(input logic [lzwh_pkg::DATA_W-1:0] b, input logic eos);
		lzwh_pkg::byte_item_t item;
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			byte_stream.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.data_byte = b;
		item.end_of_stream = eos;
		byte_stream.valid <= 1'b1;
		byte_stream.data <= item;
		@(posedge clk);
		while (!byte_stream.ready)
			@(posedge clk);
		lzw_encode_byte(b, eos);
	endtask

	task automatic send_stream(input byte_q_t bytes);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (rx_hold_len > 0) begin
			code_stream.ready <= 1'b0;
			rx_hold_len = rx_hold_len - 1;
		end else begin
			code_stream.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		lzwh_pkg::code_item_t got;
		lzwh_pkg::code_item_t want;
		if (arst_n && code_stream.valid && code_stream.ready) begin
			got = code_stream.data;
			if (pending_codes.size() == 0) begin
				report_mismatch("code with nothing pending", int'(got.code), -1);
			end else begin
				want = pending_codes.pop_front();
				if (got.code !== want.code)
					report_mismatch("code", int'(got.code), int'(want.code));
				if (got.final_code !== want.final_code)
					report_mismatch("final_code", int'(got.final_code), int'(want.final_code));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_stream.valid && byte_stream.ready) ||
			    (code_stream.valid && code_stream.ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	task automatic test_single_byte_streams();
		send_stream('{8'hFF});
		send_stream('{8'h00});
	endtask

	// Repeated pairs hit the dictionary; last byte of a stream on a hit emits a dictionary code.
	task automatic test_repeated_pairs();
		send_stream('{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41});
		send_stream('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF});
	endtask

	// Pairs sharing a first probe slot; the second stream collides at slot zero (stride 1).
	task automatic test_probe_collisions();
		send_stream('{8'h10, 8'h00, 8'h01, 8'h00, 8'h01});
		send_stream('{8'h00, 8'h00, 8'h10, 8'h01, 8'h00, 8'h00});
	endtask

	// One long stream of spread-out bytes adds many dictionary entries, mostly misses.
	task automatic test_long_stream();
		int i;
		tx_idle_pct = 36;
		rx_stall_pct = 36;
		for (i = 0; i < 160; i++)
			send_byte(lzwh_pkg::DATA_W'($urandom_range(255)), i == 159);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
	endtask

	// Receiver holds off while bytes keep coming, so the block backs up into its input.
	// The hold starts once the first byte is taken, after the clearing pass.
	task automatic test_output_backpressure();
		int i;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_byte(lzwh_pkg::DATA_W'($urandom_range(255)), 1'b0);
		rx_hold_len = 500;
		for (i = 1; i < 80; i++)
			send_byte(lzwh_pkg::DATA_W'($urandom_range(255)), i == 79);
	endtask

	task automatic test_random_streams();
		int phase;
		int sent;
		int len;
		int style;
		int nsym;
		int base;
		int i;
		logic [lzwh_pkg::DATA_W-1:0] b;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
				default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
			endcase
			sent = 0;
			while (sent < 190) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
				style = $urandom_range(3);
				nsym = $urandom_range(2, 8);
				base = $urandom_range(255);
				for (i = 0; i < len; i++) begin
					case (style)
						0: b = lzwh_pkg::DATA_W'($urandom_range(255));
						1: b = lzwh_pkg::DATA_W'(base + $urandom_range(nsym - 1));
						2: b = ($urandom_range(1) != 0) ? 8'h00 : 8'hFF;
						default: b = ($urandom_range(15) == 0)
						             ? lzwh_pkg::DATA_W'($urandom_range(255))
						             : lzwh_pkg::DATA_W'(base + (i % nsym));
					endcase
					send_byte(b, i == len - 1);
				end
				sent += len;
			end
		end
	endtask

	initial begin
		errors = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_len = 0;
		clear_dictionary();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_single_byte_streams();
		test_repeated_pairs();
		test_probe_collisions();
		test_output_backpressure();
		test_long_stream();
		test_random_streams();

		byte_stream.valid <= 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
